// ===== rtl/fys_pkg.sv =====
// Shared constants for the Fisher-Yates shuffler.
// No dependencies; imported by fys_mod, fisher_yates_shuffler_core and the testbench.
`default_nettype none
package fys_pkg;

  localparam int unsigned WORD_W     = 32;  // random word width
  localparam int unsigned BIT_CNT_W  = $clog2(WORD_W);
  localparam int unsigned POS_W      = 6;   // position field
  localparam int unsigned CARD_W     = 6;   // card field
  localparam int unsigned CFG_W      = 7;   // deck_size register
  localparam int unsigned DECK_RESET = 52;  // deck_size after reset
  localparam int unsigned OUT_DATA_W = 16;  // output word, padded to bytes

endpackage
`default_nettype wire

// ===== rtl/fisher_yates_shuffler_core.sv =====
// Fisher-Yates shuffler top level: step control, card table, output register.
// Depends on fys_pkg, fys_mod and fys_ram.
//
// Usage:
//   s_axis: one 32-bit random word per step (tdata[31:0] = random_word).
//   m_axis: one result word per step, two on the step at position 1.
//           tdata[5:0] = position, tdata[11:6] = card, tlast = end of shuffle.
//   cfg:    deck_size write (7 bits), taken only while idle; it is clamped to
//           2..MAX_CARDS and reloads the step position to size minus one.
//           A pending write holds off s_axis_tready, so both never fire together.
// Sequence: a result word follows its random word through the bit-serial
//   modulo unit, then read i, read j, write i, write j and the load of the
//   output register. The position-0 word of the final step follows after
//   a read of entry 0 and its own load of the output register.
// Input: a new random word is taken only in idle, once the last step has
//   loaded its words, paced by the modulo loop and the single RAM port pair.
// Reset: the table reads as identity (entry i holds card i) through per-entry
//   valid bits, deck_size = 52, step position = 51. No clearing pass.
// Stall: the output register holds its word while m_axis_tready is low; the
//   next step's arithmetic runs meanwhile and waits only at its own load.
`default_nettype none
module fisher_yates_shuffler_core import fys_pkg::*; #(
  parameter int unsigned MAX_CARDS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // random words
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [WORD_W-1:0]     s_axis_tdata,   // [31:0] random_word
  // result words
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] position, [11:6] card
  output logic                       m_axis_tlast,   // last
  // deck_size register
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_CARDS);
  localparam int unsigned DIV_W = $clog2(MAX_CARDS + 1);
  localparam int unsigned SIZE_RESET = (DECK_RESET > MAX_CARDS) ? MAX_CARDS : DECK_RESET;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RD_I, S_RD_J, S_WR_I, S_WR_J, S_EMIT, S_RD_0, S_EMIT0
  } state_e;

  function automatic logic [DIV_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    if (32'(v) > MAX_CARDS) begin
      return DIV_W'(MAX_CARDS);
    end else if (v < CFG_W'(2)) begin
      return DIV_W'(2);
    end else begin
      return DIV_W'(v);
    end
  endfunction

  state_e           state_q;
  logic [DIV_W-1:0] size_q;      // effective deck size
  logic [IDX_W-1:0] step_q;      // next step position
  logic [IDX_W-1:0] pos_q;       // position of the step in flight
  logic [IDX_W-1:0] j_q;         // swap partner
  logic [IDX_W-1:0] ci_q;        // card that was at pos
  logic [IDX_W-1:0] cj_q;        // card that was at j

  logic             out_valid_q;
  logic [IDX_W-1:0] out_pos_q;
  logic [IDX_W-1:0] out_card_q;
  logic             out_last_q;

  logic [MAX_CARDS-1:0] vld_q;   // entry written since reset
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_addr_q;

  logic             in_fire;
  logic             cfg_fire;
  logic             slot_free;
  logic             out_load;
  logic             div_done;
  logic [DIV_W-1:0] div_rem;
  logic [IDX_W-1:0] pos_sel;
  logic [IDX_W-1:0] size_m1;
  logic [IDX_W-1:0] rd_card;
  logic [IDX_W-1:0] ram_rdata;

  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_wdata;

  // a register write goes first; the random word waits while cfg_valid_i is high
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign out_load      = slot_free && ((state_q == S_EMIT) || (state_q == S_EMIT0));
  assign size_m1       = IDX_W'(size_q - 1'b1);

  // keep the position inside 1 .. size-1
  assign pos_sel = ((DIV_W'(step_q) >= size_q) || (step_q == '0)) ? size_m1 : step_q;

  // never-written entries read as their own index
  assign rd_card = rd_vld_q ? ram_rdata : rd_addr_q;

  fys_mod #(.DIV_W(DIV_W)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .word_i    (s_axis_tdata),
    .divisor_i (DIV_W'(pos_sel) + 1'b1),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  fys_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CARDS), .AW(IDX_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // table access per state: read i, read j, write i <= card j, write j <= card i
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pos_q;
    ram_raddr = pos_q;
    ram_wdata = rd_card;
    case (state_q)
      S_RD_I: begin
        ram_re = 1'b1;
      end
      S_RD_J: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
      end
      S_WR_I: begin
        ram_we = 1'b1;
      end
      S_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = ci_q;
      end
      S_RD_0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= DIV_W'(SIZE_RESET);
      step_q      <= IDX_W'(SIZE_RESET - 1);
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      // a load wins over the drain of the previous word
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (cfg_fire) begin
        size_q <= clamp_size(cfg_data_i);
        step_q <= IDX_W'(clamp_size(cfg_data_i) - 1'b1);
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_RD_I;
          end
        end
        S_RD_I: state_q <= S_RD_J;
        S_RD_J: state_q <= S_WR_I;
        S_WR_I: state_q <= S_WR_J;
        S_WR_J: state_q <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            if (pos_q == IDX_W'(1)) begin
              state_q <= S_RD_0;
            end else begin
              step_q  <= pos_q - 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_RD_0: state_q <= S_EMIT0;
        S_EMIT0: begin
          if (slot_free) begin
            step_q  <= size_m1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= pos_sel;
    end
    if (div_done) begin
      j_q <= IDX_W'(div_rem);
    end
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
    end
    if (state_q == S_RD_J) begin
      ci_q <= rd_card;
    end
    if (state_q == S_WR_I) begin
      cj_q <= rd_card;
    end
    if (state_q == S_EMIT && slot_free) begin
      out_pos_q  <= pos_q;
      out_card_q <= cj_q;
      out_last_q <= 1'b0;
    end else if (state_q == S_EMIT0 && slot_free) begin
      out_pos_q  <= '0;
      out_card_q <= rd_card;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OUT_DATA_W - POS_W - CARD_W)'(0),
                          CARD_W'(out_card_q), POS_W'(out_pos_q)};

`ifndef NO_ASSERTIONS
  // the modulo unit finishes only while the step waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("modulo done outside of divide state");

  // next step position always lies inside the deck
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DIV_W'(step_q) < size_q) && (step_q != '0))
    else $error("step position out of range");

  // the closing word of a shuffle carries position 0, other words do not
  a_last_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_pos_q == '0)))
    else $error("tlast does not match position 0");

  // a new word is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(out_pos_q))
    else $error("stalled output word lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/fys_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fys_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fys_mod.sv =====
// Bit-serial restoring modulo unit: word mod divisor, one dividend bit per cycle.
// Depends on fys_pkg.
`default_nettype none
module fys_mod import fys_pkg::*; #(
  parameter int unsigned DIV_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [DIV_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic      [DIV_W-1:0]  rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [WORD_W-1:0]    sh_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     div_q;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  // shift in next dividend bit, subtract when it fits
  assign trial = {rem_q, sh_q[WORD_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == BIT_CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= word_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_q << 1;
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== tb/sv/fisher_yates_shuffler_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fisher_yates_shuffler_core: random words and deck sizes in,
// every dealt position/card word predicted and checked in order.
// Depends on fys_pkg and the shuffler RTL.
module fisher_yates_shuffler_core_tb;
  import fys_pkg::*;

  localparam int unsigned MAX_CARDS   = 64;
  localparam int unsigned LATENCY     = 45;    // settle time after the last expected word
  localparam int unsigned QUIET_MAX   = 4000;  // cycles without any handshake
  localparam int unsigned LONG_HOLD   = 400;   // receiver back-pressure stretch
  localparam int unsigned RAND_PHASES = 13;
  localparam int unsigned PHASE_WORDS = 150;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CARD_W-1:0] card;
    logic              last;
  } deal_t;

  // Tracks the card order and deals out the expected result words.
  class shuffle_tracker;
    logic [CARD_W-1:0] card_order [MAX_CARDS];
    logic [CFG_W-1:0]  deck_reg;
    int unsigned       step_pos;
    deal_t             pending_deals [$];
    int unsigned       errors;

    function new();
      int k;
      for (k = 0; k < MAX_CARDS; k++) card_order[k] = CARD_W'(k);
      errors = 0;
      set_deck_size(CFG_W'(DECK_RESET));
    endfunction

    // register value clamped to 2..MAX_CARDS
    function int unsigned deck_count();
      if (deck_reg < 2) return 2;
      if (deck_reg > MAX_CARDS) return MAX_CARDS;
      return deck_reg;
    endfunction

    function void set_deck_size(logic [CFG_W-1:0] v);
      deck_reg = v;
      step_pos = deck_count() - 1;
    endfunction

    function int unsigned next_position();
      int unsigned n;
      n = deck_count();
      if (step_pos >= n || step_pos == 0) return n - 1;
      return step_pos;
    endfunction

    function int unsigned pending();
      return pending_deals.size();
    endfunction

    // one shuffle step per accepted random word
    function void note_word(logic [WORD_W-1:0] w);
      int unsigned       n, i, j;
      logic [CARD_W-1:0] t;
      deal_t             d;
      n = deck_count();
      i = next_position();
      j = w % (i + 1);
      t             = card_order[i];
      card_order[i] = card_order[j];
      card_order[j] = t;
      d = '{pos: POS_W'(i), card: card_order[i], last: 1'b0};
      pending_deals.push_back(d);
      if (i == 1) begin
        // final step also deals position 0 and closes the shuffle
        d = '{pos: '0, card: card_order[0], last: 1'b1};
        pending_deals.push_back(d);
        step_pos = n - 1;
      end else begin
        step_pos = i - 1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      deal_t got, want;
      got = '{pos: data[POS_W-1:0], card: data[POS_W+CARD_W-1:POS_W], last: last};
      if (pending_deals.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected word: pos %0d card %0d last %0b",
                   $time, got.pos, got.card, got.last);
        return;
      end
      want = pending_deals.pop_front();
      if (got.pos !== want.pos || got.card !== want.card || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: mismatch: expected pos %0d card %0d last %0b, got pos %0d card %0d last %0b",
                   $time, want.pos, want.card, want.last, got.pos, got.card, got.last);
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [WORD_W-1:0]     s_axis_tdata  = '0;   // [31:0] random_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [5:0] position, [11:6] card
  logic                  m_axis_tlast;         // last
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i    = '0;   // deck_size

  shuffle_tracker sb;
  int unsigned    send_idle   = 25;  // percent of cycles the sender idles
  int unsigned    recv_idle   = 68;  // percent of cycles the receiver stalls
  int             hold_asked  = 0;   // bumped to request one long receiver hold
  int unsigned    quiet_cycles = 0;

  fisher_yates_shuffler_core #(
    .MAX_CARDS(MAX_CARDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Word whose remainder at the coming step position is j (j <= position).
  function automatic logic [WORD_W-1:0] aim_word(input int unsigned j);
    longint unsigned span, k;
    span = longint'(sb.next_position()) + 1;
    k    = $urandom_range(32'((64'hFFFF_FFFF - j) / span));
    return WORD_W'(k * span + j);
  endfunction

  // Mix of full-range words and words aimed at the swap corners.
  function automatic logic [WORD_W-1:0] shaped_word();
    int unsigned pos;
    pos = sb.next_position();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return aim_word(0);               // swap with the bottom entry
      6, 7:       return aim_word(pos);             // entry stays in place
      8:          return aim_word($urandom_range(pos));
      default: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return 32'h8000_0000 | $urandom_range(255);
        endcase
      end
    endcase
  endfunction

  // Called and returns at a falling edge; tvalid stays high into the next call.
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  // Only written once every expected word has come out.
  task automatic write_deck_size(input logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_deck_size(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin : sink
    int unsigned hold_left;
    int          hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] size_pick [7];
    int               p;
    size_pick = '{7'd52, 7'd2, 7'd64, 7'd3, 7'd127, 7'd1, 7'd13};
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset deck of 52: word extremes, self-swap, alternating bits
    send_word('0);
    send_word('1);
    send_word(aim_word(sb.next_position()));
    send_word(32'h8000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    // smallest deck: every word is a full shuffle
    write_deck_size(7'd2);
    send_word('0);
    send_word('1);
    send_word(32'd1);
    send_word(32'd2);
    // sizes below the range clamp to 2
    write_deck_size(7'd0);
    send_word($urandom);
    send_word($urandom);
    write_deck_size(7'd1);
    send_word($urandom);
    send_word($urandom);
    // full table
    write_deck_size(7'd64);
    send_word('1);
    send_word(aim_word(63));
    send_word('0);
    // sizes above the range clamp to MAX_CARDS
    write_deck_size(7'd127);
    send_word($urandom);
    send_word($urandom);
    write_deck_size(7'd65);
    send_word($urandom);
    send_word($urandom);
    // shrink mid-table: upper entries keep their cards
    write_deck_size(7'd3);
    send_word(aim_word(2));
    send_word(aim_word(0));
    send_word('1);

    for (p = 0; p < RAND_PHASES; p++) begin
      if (p < 5) begin
        send_idle = 25;
        recv_idle = 68;
      end else if (p < 9) begin
        send_idle = 68;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_deck_size(p < 7 ? size_pick[p] : CFG_W'($urandom_range(127)));
      // fill the block while the receiver holds off
      if (p == 9) hold_asked++;
      repeat (PHASE_WORDS) send_word(shaped_word());
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== fisher_yates_shuffler_core.f =====
rtl/fys_pkg.sv
rtl/fys_ram.sv
rtl/fys_mod.sv
rtl/fisher_yates_shuffler_core.sv
tb/sv/fisher_yates_shuffler_core_tb.sv
